// File: rtl/core/spiral_order_readout_top_assert.svh
// ----------------------------------------------------------------------------
// Spiral order readout assertion macros
// Shared property templates for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SPIRAL_ORDER_READOUT_TOP_ASSERT_SVH
`define SPIRAL_ORDER_READOUT_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define SOR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define SOR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/sor_pkg.sv
// ----------------------------------------------------------------------------
// Spiral order readout package
// Types, codes and defaults shared by the spiral order readout modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sor_pkg;

  localparam int CNT_W        = 5;
  localparam int VAL_W        = 32;
  localparam int CFG_IDX_W    = 1;
  localparam int MAX_ROWS_DEF = 16;
  localparam int MAX_COLS_DEF = 16;
  localparam int COUNT_RESET  = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_READ = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_UP    = 2'd3
  } dir_e;

  typedef enum logic {
    ST_LOAD = 1'b0,
    ST_READ = 1'b1
  } state_e;

  typedef struct packed {
    func_e                   func;
    logic signed [VAL_W-1:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] out_value;
    logic                    is_last;
  } out_item_t;

  typedef struct packed {
    logic restart;
    logic load_wr;
    logic spiral_init;
    logic rd_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cfg_clear;
    logic load_last;
    logic emit_last;
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/core/sor_ram.sv
// ----------------------------------------------------------------------------
// Spiral order readout RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sor_ram #(
  parameter int Width = 32,
  parameter int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/sor_datapath.sv
// ----------------------------------------------------------------------------
// Spiral order readout datapath
// Size registers, load and spiral position counters, and the matrix memory.
// ----------------------------------------------------------------------------
`default_nettype none

module sor_datapath #(
  parameter int MaxRows = sor_pkg::MAX_ROWS_DEF,
  parameter int MaxCols = sor_pkg::MAX_COLS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [sor_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [sor_pkg::CNT_W-1:0]       cfg_data_i,
  input  wire sor_pkg::in_item_t               in_data_i,
  input  wire sor_pkg::ctrl_cmd_t              cmd_i,
  output sor_pkg::dp_status_t                  status_o,
  output sor_pkg::out_item_t                   out_data_o
);

  localparam int Depth = MaxRows * MaxCols;
  localparam int Rw    = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int Cw    = (MaxCols > 1) ? $clog2(MaxCols) : 1;
  localparam int Aw    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int Tw    = $clog2(Depth + 1);
  localparam int RcW   = ($clog2(MaxRows + 1) > sor_pkg::CNT_W) ?
                         $clog2(MaxRows + 1) : sor_pkg::CNT_W;
  localparam int CcW   = ($clog2(MaxCols + 1) > sor_pkg::CNT_W) ?
                         $clog2(MaxCols + 1) : sor_pkg::CNT_W;

  logic [sor_pkg::CNT_W-1:0] row_cnt_q, col_cnt_q;
  logic [Rw-1:0]             rows_m1, cols_m1_r;
  logic [Cw-1:0]             cols_m1;
  logic [Tw-1:0]             total;
  logic [Aw-1:0]             total_m1;

  logic [Rw-1:0]   load_row_q, load_row_d;
  logic [Cw-1:0]   load_col_q, load_col_d;
  logic [Rw-1:0]   cur_row_q, cur_row_d, bnd_top_q, bnd_top_d, bnd_bot_q, bnd_bot_d;
  logic [Cw-1:0]   cur_col_q, cur_col_d, bnd_lft_q, bnd_lft_d, bnd_rgt_q, bnd_rgt_d;
  sor_pkg::dir_e   dir_q, dir_d;
  logic [Aw-1:0]   emit_cnt_q, emit_cnt_d;
  logic            last_q;
  logic            cfg_hit;
  logic [Aw-1:0]   waddr, raddr;
  logic [sor_pkg::VAL_W-1:0] rdata;

  assign cfg_hit = cfg_we_i && ((cfg_idx_i == sor_pkg::REG_ROW_COUNT) ||
                                (cfg_idx_i == sor_pkg::REG_COL_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= sor_pkg::CNT_W'(sor_pkg::COUNT_RESET);
      col_cnt_q <= sor_pkg::CNT_W'(sor_pkg::COUNT_RESET);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == sor_pkg::REG_ROW_COUNT) begin
        row_cnt_q <= cfg_data_i;
      end else if (cfg_idx_i == sor_pkg::REG_COL_COUNT) begin
        col_cnt_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    if (row_cnt_q == '0) begin
      rows_m1 = '0;
    end else if (RcW'(row_cnt_q) > RcW'(MaxRows)) begin
      rows_m1 = Rw'(MaxRows - 1);
    end else begin
      rows_m1 = Rw'(RcW'(row_cnt_q) - RcW'(1));
    end
    if (col_cnt_q == '0) begin
      cols_m1 = '0;
    end else if (CcW'(col_cnt_q) > CcW'(MaxCols)) begin
      cols_m1 = Cw'(MaxCols - 1);
    end else begin
      cols_m1 = Cw'(CcW'(col_cnt_q) - CcW'(1));
    end
  end

  assign cols_m1_r = '0;
  assign total    = (Tw'(rows_m1) + Tw'(1)) * (Tw'(cols_m1) + Tw'(1)) + Tw'(cols_m1_r);
  assign total_m1 = Aw'(total - Tw'(1));

  assign status_o.cfg_clear = cfg_hit;
  assign status_o.load_last = (load_row_q == rows_m1) && (load_col_q == cols_m1);
  assign status_o.emit_last = (emit_cnt_q == total_m1);

  always_comb begin
    load_row_d = load_row_q;
    load_col_d = load_col_q;
    cur_row_d  = cur_row_q;
    cur_col_d  = cur_col_q;
    bnd_top_d  = bnd_top_q;
    bnd_bot_d  = bnd_bot_q;
    bnd_lft_d  = bnd_lft_q;
    bnd_rgt_d  = bnd_rgt_q;
    dir_d      = dir_q;
    emit_cnt_d = emit_cnt_q;

    if (cmd_i.load_wr) begin
      if (load_col_q == cols_m1) begin
        load_col_d = '0;
        load_row_d = load_row_q + Rw'(1);
      end else begin
        load_col_d = load_col_q + Cw'(1);
      end
    end

    if (cmd_i.rd_en && !status_o.emit_last) begin
      emit_cnt_d = emit_cnt_q + Aw'(1);
      case (dir_q)
        sor_pkg::DIR_RIGHT: begin
          if (cur_col_q < bnd_rgt_q) begin
            cur_col_d = cur_col_q + Cw'(1);
          end else begin
            bnd_top_d = bnd_top_q + Rw'(1);
            dir_d     = sor_pkg::DIR_DOWN;
            cur_row_d = cur_row_q + Rw'(1);
          end
        end
        sor_pkg::DIR_DOWN: begin
          if (cur_row_q < bnd_bot_q) begin
            cur_row_d = cur_row_q + Rw'(1);
          end else begin
            bnd_rgt_d = bnd_rgt_q - Cw'(1);
            dir_d     = sor_pkg::DIR_LEFT;
            cur_col_d = cur_col_q - Cw'(1);
          end
        end
        sor_pkg::DIR_LEFT: begin
          if (cur_col_q > bnd_lft_q) begin
            cur_col_d = cur_col_q - Cw'(1);
          end else begin
            bnd_bot_d = bnd_bot_q - Rw'(1);
            dir_d     = sor_pkg::DIR_UP;
            cur_row_d = cur_row_q - Rw'(1);
          end
        end
        default: begin
          if (cur_row_q > bnd_top_q) begin
            cur_row_d = cur_row_q - Rw'(1);
          end else begin
            bnd_lft_d = bnd_lft_q + Cw'(1);
            dir_d     = sor_pkg::DIR_RIGHT;
            cur_col_d = cur_col_q + Cw'(1);
          end
        end
      endcase
    end

    if (cmd_i.spiral_init) begin
      bnd_top_d  = '0;
      bnd_lft_d  = '0;
      bnd_bot_d  = rows_m1;
      bnd_rgt_d  = cols_m1;
      cur_row_d  = '0;
      cur_col_d  = '0;
      dir_d      = sor_pkg::DIR_RIGHT;
      emit_cnt_d = '0;
      load_row_d = '0;
      load_col_d = '0;
    end

    if (cmd_i.restart) begin
      load_row_d = '0;
      load_col_d = '0;
      emit_cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_row_q <= '0;
      load_col_q <= '0;
      cur_row_q  <= '0;
      cur_col_q  <= '0;
      bnd_top_q  <= '0;
      bnd_bot_q  <= '0;
      bnd_lft_q  <= '0;
      bnd_rgt_q  <= '0;
      dir_q      <= sor_pkg::DIR_RIGHT;
      emit_cnt_q <= '0;
    end else begin
      load_row_q <= load_row_d;
      load_col_q <= load_col_d;
      cur_row_q  <= cur_row_d;
      cur_col_q  <= cur_col_d;
      bnd_top_q  <= bnd_top_d;
      bnd_bot_q  <= bnd_bot_d;
      bnd_lft_q  <= bnd_lft_d;
      bnd_rgt_q  <= bnd_rgt_d;
      dir_q      <= dir_d;
      emit_cnt_q <= emit_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      last_q <= status_o.emit_last;
    end
  end

  assign waddr = Aw'(load_row_q) * Aw'(MaxCols) + Aw'(load_col_q);
  assign raddr = Aw'(cur_row_q) * Aw'(MaxCols) + Aw'(cur_col_q);

  sor_ram #(
    .Width (sor_pkg::VAL_W),
    .Depth (Depth)
  ) u_sor_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_wr),
    .waddr_i (waddr),
    .wdata_i (in_data_i.elem_value),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_data_o.out_value = rdata;
  assign out_data_o.is_last   = last_q;

endmodule

`default_nettype wire

// File: rtl/core/sor_ctrl.sv
// ----------------------------------------------------------------------------
// Spiral order readout controller
// Load/readout state machine, input handshake and output valid register.
// ----------------------------------------------------------------------------
`default_nettype none

module sor_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire sor_pkg::func_e      in_func_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  wire sor_pkg::dp_status_t status_i,
  output sor_pkg::ctrl_cmd_t       cmd_o
);

  sor_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;

  assign in_ready_o  = (in_func_i == sor_pkg::FUNC_LOAD) || !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sor_pkg::ST_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;

    case (state_q)
      sor_pkg::ST_LOAD: begin
        if (accept && (in_func_i == sor_pkg::FUNC_LOAD)) begin
          cmd_o.load_wr = 1'b1;
          if (status_i.load_last) begin
            cmd_o.spiral_init = 1'b1;
            state_d           = sor_pkg::ST_READ;
          end
        end
      end
      sor_pkg::ST_READ: begin
        if (accept && (in_func_i == sor_pkg::FUNC_READ)) begin
          cmd_o.rd_en = 1'b1;
          if (status_i.emit_last) begin
            cmd_o.restart = 1'b1;
            state_d       = sor_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        state_d = sor_pkg::ST_LOAD;
      end
    endcase

    if (status_i.cfg_clear) begin
      cmd_o.restart = 1'b1;
      state_d       = sor_pkg::ST_LOAD;
    end

    if (cmd_o.rd_en) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/spiral_order_readout_top.sv
// ----------------------------------------------------------------------------
// Spiral order readout top level
// Stores a matrix in row-major order and returns it in clockwise spiral order.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i/in_ready_o   in_data_i (func, elem_value)
//   out      output     out_valid_o/out_ready_i out_data_o (out_value, is_last)
//   cfg      input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// One transaction is taken per cycle while in_ready_o is high; a read returns its result
// in the cycle after it is taken, from the registered read port of the matrix memory.
// Loads are always taken; a read waits while an earlier result is still held.
// Reset needs no clearing pass; the block comes up empty with 4 by 4 size.
// ----------------------------------------------------------------------------
`default_nettype none

module spiral_order_readout_top #(
  parameter int MaxRows = sor_pkg::MAX_ROWS_DEF,
  parameter int MaxCols = sor_pkg::MAX_COLS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire sor_pkg::in_item_t             in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output sor_pkg::out_item_t                 out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [sor_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [sor_pkg::CNT_W-1:0]     cfg_data_i
);

  sor_pkg::ctrl_cmd_t  cmd;
  sor_pkg::dp_status_t status;

  sor_ctrl u_sor_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_func_i   (in_data_i.func),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sor_datapath #(
    .MaxRows (MaxRows),
    .MaxCols (MaxCols)
  ) u_sor_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// File: rtl/core/sor_checker.sv
// ----------------------------------------------------------------------------
// Spiral order readout checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "spiral_order_readout_top_assert.svh"

module sor_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire sor_pkg::in_item_t  in_data_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire sor_pkg::out_item_t out_data_o
);

  logic read_acc;
  logic out_stall;

  assign read_acc  = in_valid_i && in_ready_o && (in_data_i.func == sor_pkg::FUNC_READ);
  assign out_stall = out_valid_o && !out_ready_i;

  `SOR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_data_o), "stalled result changed")
  `SOR_ASSERT_NEXT(a_out_from_read, clk_i, rst_ni, !read_acc && !out_stall, !out_valid_o, "result without a read transaction")
  `SOR_ASSERT_NOW(a_load_ready, clk_i, rst_ni, in_valid_i && (in_data_i.func == sor_pkg::FUNC_LOAD), in_ready_o, "load transaction refused")
  `SOR_ASSERT_NOW(a_no_read_on_stall, clk_i, rst_ni, out_stall, !read_acc, "read taken while result stalled")

endmodule

bind spiral_order_readout_top sor_checker u_sor_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
